// ----- src/rms_pkg.sv -----
// rms_pkg: shared types and constants for the run-length mask span stamper
// beat structs for both channels, the queue entry and the parser phase codes
// depends on nothing
package rms_pkg;

  // input beat: one byte of the encoded mask plus the stamp header fields
  typedef struct packed {
    logic        start_req;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic        clear;
    logic [7:0]  data_byte;
  } in_beat_t;

  // output beat: one write command for the cell map
  typedef struct packed {
    logic [23:0] map_address;
    logic [7:0]  run_length;
    logic        cell_value;
    logic        outside;
    logic        stamp_done;
  } out_beat_t;

  // signed widths of map column and row before the bounds check
  localparam int COL_W = 21;
  localparam int ROW_W = 19;

  // register widths and addresses
  localparam int REG_W  = 13;
  localparam int ADDR_W = 3;
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  // queue between parser and address unit
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // classified command handed from parser to address unit
  typedef struct packed {
    logic                    done;
    logic signed [COL_W-1:0] col;
    logic signed [ROW_W-1:0] row;
    logic [7:0]              size;
    logic                    cell_value;
  } cmd_t;

  // parser phases
  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_SIZE  = 4'b0100,
    PH_DATA  = 4'b1000
  } phase_t;

endpackage

// ----- src/rle_mask_span_stamper.sv -----
// rle_mask_span_stamper: top level of the run-length mask span stamper
// holds the map size registers and ties parser, queue and address unit
// depends on rms_pkg, rms_front, rms_queue, rms_back
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-------------------------------
//   in      | in        | in_valid / in_stall   | rms_pkg::in_beat_t, one byte
//   out     | out       | out_valid / out_stall | rms_pkg::out_beat_t, one command
//   apb     | in        | psel/penable/pready   | map_width (0x0), map_height (0x4)
//
// one input byte per cycle; a byte is taken whenever the four-entry command
// queue has room, so in_stall rises only after out_stall has held it full.
// a span command passes from its size byte through the queue, the product stage and the add.
// reset clears the parser, queue and output valid; the registers go to 1024.
// no clearing pass: the block takes beats from the first cycle after reset.
module rle_mask_span_stamper #(
  parameter int MASK_ROWS   = 256,
  parameter int MASK_HALF   = 128,
  parameter int MAX_MAP_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rms_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rms_pkg::out_beat_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rms_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [rms_pkg::REG_W-1:0] map_width;
  logic [rms_pkg::REG_W-1:0] map_height;
  logic                      cfg_wr;

  logic                      q_full;
  logic                      push;
  rms_pkg::cmd_t             push_cmd;
  logic                      pop;
  logic                      q_valid;
  rms_pkg::cmd_t             q_cmd;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= rms_pkg::REG_W'(1024);
      map_height <= rms_pkg::REG_W'(1024);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rms_pkg::REG_MAP_WIDTH:  map_width  <= pwdata[rms_pkg::REG_W-1:0];
        rms_pkg::REG_MAP_HEIGHT: map_height <= pwdata[rms_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      rms_pkg::REG_MAP_WIDTH:  prdata = {19'b0, map_width};
      rms_pkg::REG_MAP_HEIGHT: prdata = {19'b0, map_height};
      default:                 prdata = '0;
    endcase
  end

  rms_front #(
    .MASK_ROWS (MASK_ROWS),
    .MASK_HALF (MASK_HALF)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  rms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  rms_back #(
    .MAX_MAP_DIM (MAX_MAP_DIM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .pop        (pop),
    .map_width  (map_width),
    .map_height (map_height),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- src/rms_front.sv -----
// rms_front: byte parser of the run-length mask stream
// tracks rows, spans and data bytes and emits span or end-of-stamp commands
// depends on rms_pkg
module rms_front #(
  parameter int MASK_ROWS = 256,
  parameter int MASK_HALF = 128
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rms_pkg::in_beat_t in_data,
  input  logic             q_full,
  output logic             push,
  output rms_pkg::cmd_t    push_cmd
);

  localparam int RIW = $clog2(MASK_ROWS + 1);
  localparam logic [RIW-1:0] ROW_END = RIW'(MASK_ROWS);

  // parse state
  logic                  stamp_active, stamp_active_next;
  rms_pkg::phase_t       phase, phase_next;
  logic [RIW-1:0]        row_index, row_index_next;
  logic [7:0]            spans_left, spans_left_next;
  logic [7:0]            data_left, data_left_next;
  logic [17:0]           column_cursor, column_cursor_next;
  logic [15:0]           latched_x, latched_x_next;
  logic [15:0]           latched_y, latched_y_next;
  logic                  latched_clear, latched_clear_next;

  logic                  accept;
  logic                  emit;
  rms_pkg::cmd_t         cmd;
  logic                  span_end;
  logic                  row_end;
  logic [7:0]            spans_dec;
  logic [7:0]            data_dec;
  logic [RIW-1:0]        row_inc;
  logic [7:0]            b;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.data_byte;

  // next parse state for the byte on the input
  always_comb begin
    stamp_active_next  = stamp_active;
    phase_next         = phase;
    row_index_next     = row_index;
    spans_left_next    = spans_left;
    data_left_next     = data_left;
    column_cursor_next = column_cursor;
    latched_x_next     = latched_x;
    latched_y_next     = latched_y;
    latched_clear_next = latched_clear;
    emit      = 1'b0;
    cmd       = '0;
    span_end  = 1'b0;
    row_end   = 1'b0;
    spans_dec = '0;
    data_dec  = '0;
    row_inc   = '0;

    // a start byte restarts the stamp regardless of the current one
    if (in_data.start_req) begin
      latched_x_next     = in_data.origin_x;
      latched_y_next     = in_data.origin_y;
      latched_clear_next = in_data.clear;
      stamp_active_next  = 1'b1;
      phase_next         = rms_pkg::PH_COUNT;
      row_index_next     = '0;
      spans_left_next    = '0;
      data_left_next     = '0;
      column_cursor_next = '0;
    end

    if (stamp_active_next) begin
      unique case (phase_next)
        rms_pkg::PH_COUNT: begin
          column_cursor_next = '0;
          if (b == 8'd0) begin
            row_end = 1'b1;
          end else begin
            spans_left_next = b;
            phase_next      = rms_pkg::PH_SKIP;
          end
        end
        rms_pkg::PH_SKIP: begin
          column_cursor_next = column_cursor_next + 18'(b);
          phase_next         = rms_pkg::PH_SIZE;
        end
        rms_pkg::PH_SIZE: begin
          if (b != 8'd0) begin
            emit           = 1'b1;
            cmd.done       = 1'b0;
            cmd.col        = $signed({5'b0, latched_x_next})
                           + $signed({3'b0, column_cursor_next})
                           - $signed(rms_pkg::COL_W'(MASK_HALF));
            cmd.row        = $signed({3'b0, latched_y_next})
                           + $signed(rms_pkg::ROW_W'(row_index_next))
                           - $signed(rms_pkg::ROW_W'(MASK_HALF));
            cmd.size       = b;
            cmd.cell_value = !latched_clear_next;
            column_cursor_next = column_cursor_next + 18'(b);
            data_left_next     = b;
            phase_next         = rms_pkg::PH_DATA;
          end else begin
            span_end = 1'b1;
          end
        end
        rms_pkg::PH_DATA: begin
          data_dec       = data_left_next - 8'(data_left_next != 8'd0);
          data_left_next = data_dec;
          if (data_dec == 8'd0) begin
            span_end = 1'b1;
          end
        end
        default: begin
          phase_next = rms_pkg::PH_COUNT;
        end
      endcase
    end

    // end of a span: count it off, maybe end the row
    if (span_end) begin
      spans_dec       = spans_left_next - 8'(spans_left_next != 8'd0);
      spans_left_next = spans_dec;
      if (spans_dec == 8'd0) begin
        row_end = 1'b1;
      end else begin
        phase_next = rms_pkg::PH_SKIP;
      end
    end

    // end of a row: the last row closes the stamp with a done marker
    if (row_end) begin
      row_inc            = row_index_next + RIW'(1);
      phase_next         = rms_pkg::PH_COUNT;
      spans_left_next    = '0;
      data_left_next     = '0;
      column_cursor_next = '0;
      if (row_inc >= ROW_END) begin
        stamp_active_next = 1'b0;
        row_index_next    = '0;
        emit              = 1'b1;
        cmd               = '0;
        cmd.done          = 1'b1;
      end else begin
        row_index_next = row_inc;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stamp_active  <= 1'b0;
      phase         <= rms_pkg::PH_COUNT;
      row_index     <= '0;
      spans_left    <= '0;
      data_left     <= '0;
      column_cursor <= '0;
    end else if (accept) begin
      stamp_active  <= stamp_active_next;
      phase         <= phase_next;
      row_index     <= row_index_next;
      spans_left    <= spans_left_next;
      data_left     <= data_left_next;
      column_cursor <= column_cursor_next;
    end
  end

  // stamp header fields
  always_ff @(posedge clk) begin
    if (accept) begin
      latched_x     <= latched_x_next;
      latched_y     <= latched_y_next;
      latched_clear <= latched_clear_next;
    end
  end

  assign push     = accept && emit;
  assign push_cmd = cmd;

  // idle parser sits at the start of row zero
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !stamp_active |-> (phase == rms_pkg::PH_COUNT) && (row_index == '0))
    else $error("idle parser not at row start");

endmodule

// ----- src/rms_queue.sv -----
// rms_queue: short command queue between the parser and the address unit
// register array with read and write pointers and a fill count
// depends on rms_pkg
module rms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rms_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rms_pkg::cmd_t head_cmd
);

  rms_pkg::cmd_t                 entries [rms_pkg::QUEUE_DEPTH];
  logic [rms_pkg::QPTR_W-1:0]    wr_ptr;
  logic [rms_pkg::QPTR_W-1:0]    rd_ptr;
  logic [rms_pkg::QCNT_W-1:0]    count;

  assign full       = (count == rms_pkg::QCNT_W'(rms_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rms_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rms_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rms_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rms_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (full |-> !push) and (!head_valid |-> !pop))
    else $error("queue pushed when full or popped when empty");

endmodule

// ----- src/rms_back.sv -----
// rms_back: bounds check and linear address for each queued command
// stage one checks bounds and multiplies row by width, stage two adds column
// depends on rms_pkg
module rms_back #(
  parameter int MAX_MAP_DIM = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  rms_pkg::cmd_t               q_cmd,
  output logic                        pop,
  input  logic [rms_pkg::REG_W-1:0]   map_width,
  input  logic [rms_pkg::REG_W-1:0]   map_height,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rms_pkg::out_beat_t          out_data
);

  localparam logic [16:0] DIM_CAP = 17'(MAX_MAP_DIM);

  logic [16:0]                    w_cap;
  logic [16:0]                    h_cap;
  logic signed [rms_pkg::COL_W-1:0] col_end;
  logic                           outside;
  logic [25:0]                    prod;
  logic [25:0]                    sum;

  logic                           out_free;
  logic                           s1_load_ok;
  logic                           s1_adv;

  // stage one registers
  logic                           s1_valid;
  logic                           s1_done;
  logic                           s1_outside;
  logic [25:0]                    s1_prod;
  logic [rms_pkg::REG_W-1:0]      s1_col;
  logic [7:0]                     s1_len;
  logic                           s1_val;

  // stage hand-off
  assign out_free   = !out_valid || !out_stall;
  assign s1_adv     = s1_valid && out_free;
  assign s1_load_ok = !s1_valid || out_free;
  assign pop        = q_valid && s1_load_ok;

  // map size capped at the largest supported dimension
  always_comb begin
    w_cap = ({4'b0, map_width} < DIM_CAP) ? {4'b0, map_width} : DIM_CAP;
    h_cap = ({4'b0, map_height} < DIM_CAP) ? {4'b0, map_height} : DIM_CAP;
  end

  // bounds check and row product
  always_comb begin
    col_end = q_cmd.col + $signed({13'b0, q_cmd.size});
    outside = !q_cmd.done &&
              (q_cmd.col[rms_pkg::COL_W-1] ||
               (col_end > $signed({4'b0, w_cap})) ||
               q_cmd.row[rms_pkg::ROW_W-1] ||
               (q_cmd.row >= $signed({2'b0, h_cap})));
    prod    = {13'b0, q_cmd.row[rms_pkg::REG_W-1:0]} * {13'b0, w_cap[rms_pkg::REG_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load_ok) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_done    <= q_cmd.done;
      s1_outside <= outside;
      s1_prod    <= prod;
      s1_col     <= q_cmd.col[rms_pkg::REG_W-1:0];
      s1_len     <= q_cmd.size;
      s1_val     <= q_cmd.cell_value;
    end
  end

  // address add into the output register
  assign sum = s1_prod + 26'(s1_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.map_address <= (s1_done || s1_outside) ? 24'd0 : sum[23:0];
      out_data.run_length  <= s1_len;
      out_data.cell_value  <= s1_val;
      out_data.outside     <= s1_outside;
      out_data.stamp_done  <= s1_done;
    end
  end

  a_outside_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.outside) |-> (out_data.map_address == 24'd0) &&
                                        !out_data.stamp_done)
    else $error("outside span carries an address or done flag");

  a_done_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.stamp_done) |-> (out_data.run_length == 8'd0) &&
                                           !out_data.cell_value &&
                                           (out_data.map_address == 24'd0))
    else $error("done marker carries span fields");

endmodule
